/* rtl/shsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package shsq_pkg;

  // Quantizer modes; code three behaves as proportional.
  localparam logic [1:0] QM_CLAMP   = 2'd0;
  localparam logic [1:0] QM_NEAREST = 2'd1;
  localparam logic [1:0] QM_SPREAD  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MASK   = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  localparam logic [1:0]  MODE_RESET   = QM_SPREAD;
  localparam logic [11:0] MASK_RESET   = 12'hFFF;
  localparam logic [2:0]  ENABLE_RESET = 3'd0;

  // Output limit: five volts at 4096 per volt.
  localparam int VMAX = 20480;

  typedef struct packed {
    logic capture;
    logic prep;
    logic search;
    logic pick;
    logic mul;
    logic volt;
    logic commit;
  } shsq_cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic search_done;
    logic out_free;
  } shsq_stat_t;

endpackage

`default_nettype wire

/* rtl/shsq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module shsq_ctrl import shsq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire shsq_stat_t stat,
  output shsq_cmd_t       cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_PICK   = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_VOLT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          // drop requests for channels that do not exist
          if (stat.chan_ok) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_VOLT;
      end
      ST_VOLT: begin
        cmd.volt   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/shsq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module shsq_datapath import shsq_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire shsq_cmd_t          cmd,
  output shsq_stat_t              stat,
  input  wire logic [1:0]         channel,
  input  wire logic signed [15:0] sample,
  input  wire logic [1:0]         quant_mode,
  input  wire logic [11:0]        scale_mask,
  input  wire logic [2:0]         quant_enable,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [1:0]              out_channel,
  output logic signed [15:0]      held_value,
  output logic                    changed
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [9:0] third_frac(input logic [1:0] rem);
    case (rem)
      2'd0:    third_frac = 10'd0;
      2'd1:    third_frac = 10'd341;
      2'd2:    third_frac = 10'd683;
      default: third_frac = 10'd0;
    endcase
  endfunction

  logic signed [15:0] held [CHANNELS];

  // captured request
  logic [1:0]         ch_r;
  logic signed [15:0] s_r;

  // prep results
  logic [1:0]         mode_r;
  logic [11:0]        mask_r;
  logic               en_r;
  logic signed [15:0] prev_r;
  logic [15:0]        f_r;
  logic signed [4:0]  ap_r;
  logic [3:0]         tgt_r;
  logic signed [4:0]  offp_r;

  // search state
  logic signed [5:0]  r_r, l_r;
  logic [3:0]         rs_r, ls_r;
  logic               rfound, lfound;
  logic [3:0]         k_r, cnt_r, sel_r;
  logic               pfound;

  // conversion pipeline
  logic signed [7:0]  note_r;
  logic               keep_r;
  logic [7:0]         u_r;
  logic [15:0]        prod_r;
  logic signed [15:0] v_r;

  // prep logic
  logic [11:0]        mask_eff;
  logic [3:0]         en_ext;
  logic [1:0]         mode_c;
  logic [11:0]        fr;
  logic [15:0]        f_c;
  logic [16:0]        a_sum;
  logic [3:0]         a_c, as_c;
  logic               tie;
  logic signed [4:0]  ap_c;
  logic [3:0]         m_c;
  logic [15:0]        pm_c;
  logic [16:0]        np_sum;
  logic [3:0]         np_c;
  logic               wrap;

  assign mask_eff = (scale_mask == 12'd0) ? 12'd1 : scale_mask;
  assign en_ext   = {1'b0, quant_enable};
  assign fr       = s_r[11:0];
  assign f_c      = {4'd0, fr} * 16'd12;
  assign a_sum    = {1'b0, f_c} + 17'd2048;
  assign a_c      = a_sum[15:12];
  assign as_c     = (a_c == 4'd12) ? 4'd0 : a_c;
  assign tie      = (f_c[11:0] == 12'd2048);
  // negative samples round halves away from zero in clamp mode
  assign ap_c     = (s_r[15] && tie) ? ($signed({1'b0, a_c}) - 5'sd1)
                                     : $signed({1'b0, a_c});
  assign m_c      = 4'($countones(mask_eff));
  assign pm_c     = {12'd0, m_c} * {4'd0, fr};
  assign np_sum   = {1'b0, pm_c} + 17'd2048;
  assign np_c     = np_sum[15:12];
  assign wrap     = (np_c == m_c);

  always_comb begin
    case (quant_mode)
      QM_CLAMP:   mode_c = QM_CLAMP;
      QM_NEAREST: mode_c = QM_NEAREST;
      default:    mode_c = QM_SPREAD;
    endcase
  end

  // search logic
  logic [15:0] mask_x;
  assign mask_x = {4'd0, mask_r};

  // pick logic
  logic signed [7:0]  off12, offp12, note_clamp, note_near, note_prop, note_c;
  logic signed [5:0]  win;
  logic [3:0]         aps;
  logic signed [18:0] fv, dr_raw, dl_raw;
  logic [18:0]        dr, dl;

  assign off12  = {{4{s_r[15]}}, s_r[15:12]} * 8'sd12;
  assign offp12 = {{3{offp_r[4]}}, offp_r} * 8'sd12;

  assign note_clamp = off12 + {{3{ap_r[4]}}, ap_r};
  assign aps = (ap_r == -5'sd1) ? 4'd11 :
               (ap_r == 5'sd12) ? 4'd0  : ap_r[3:0];

  assign fv     = $signed({3'd0, f_r});
  assign dr_raw = fv - $signed({r_r[5], r_r, 12'd0});
  assign dl_raw = fv - $signed({l_r[5], l_r, 12'd0});
  assign dr     = dr_raw[18] ? 19'(-dr_raw) : dr_raw;
  assign dl     = dl_raw[18] ? 19'(-dl_raw) : dl_raw;
  // ties go to the upper note
  assign win       = (dr <= dl) ? r_r : l_r;
  assign note_near = off12 + {{2{win[5]}}, win};
  assign note_prop = offp12 + $signed({4'd0, sel_r});

  always_comb begin
    case (mode_r)
      QM_CLAMP:   note_c = note_clamp;
      QM_NEAREST: note_c = note_near;
      default:    note_c = note_prop;
    endcase
  end

  // note to volts: round(n * 1024 / 3), n offset by 129 to stay positive
  logic [8:0]         u9;
  logic [6:0]         qp;
  logic [7:0]         three_q, rem_full;
  logic signed [7:0]  qs;
  logic signed [17:0] v_q, v_sel, v_lim;

  assign u9       = {note_r[7], note_r} + 9'd129;
  assign qp       = prod_r[15:9];
  assign three_q  = {1'b0, qp} + {qp, 1'b0};
  assign rem_full = u_r - three_q;
  assign qs       = $signed({1'b0, qp}) - 8'sd43;
  assign v_q      = $signed({qs, 10'd0}) + $signed({8'd0, third_frac(rem_full[1:0])});

  always_comb begin
    if (!en_r) begin
      v_sel = {{2{s_r[15]}}, s_r};
    end else if (keep_r) begin
      v_sel = {{2{prev_r[15]}}, prev_r};
    end else begin
      v_sel = v_q;
    end
    if (v_sel < -VMAX) begin
      v_lim = 18'(-VMAX);
    end else if (v_sel > VMAX) begin
      v_lim = 18'(VMAX);
    end else begin
      v_lim = v_sel;
    end
  end

  assign stat.chan_ok     = ({30'd0, channel} < CHANNELS);
  assign stat.search_done = !en_r || (mode_r == QM_CLAMP) ||
                            ((mode_r == QM_NEAREST) && rfound && lfound) ||
                            ((mode_r == QM_SPREAD) && pfound);
  assign stat.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r <= channel;
      s_r  <= sample;
    end

    if (cmd.prep) begin
      mode_r <= mode_c;
      mask_r <= mask_eff;
      en_r   <= en_ext[ch_r];
      prev_r <= held[IDX_W'(ch_r)];
      f_r    <= f_c;
      ap_r   <= ap_c;
      tgt_r  <= wrap ? 4'd0 : np_c;
      offp_r <= {s_r[15], s_r[15:12]} + {4'd0, wrap};
      r_r    <= $signed({2'd0, a_c});
      l_r    <= $signed({2'd0, a_c});
      rs_r   <= as_c;
      ls_r   <= as_c;
      rfound <= 1'b0;
      lfound <= 1'b0;
      k_r    <= 4'd0;
      cnt_r  <= 4'd0;
      pfound <= 1'b0;
    end

    if (cmd.search) begin
      if (mode_r == QM_NEAREST) begin
        // walk outward one semitone a cycle until each side hits a note
        if (!rfound) begin
          if (mask_x[rs_r]) begin
            rfound <= 1'b1;
          end else begin
            r_r  <= r_r + 6'sd1;
            rs_r <= (rs_r == 4'd11) ? 4'd0 : rs_r + 4'd1;
          end
        end
        if (!lfound) begin
          if (mask_x[ls_r]) begin
            lfound <= 1'b1;
          end else begin
            l_r  <= l_r - 6'sd1;
            ls_r <= (ls_r == 4'd0) ? 4'd11 : ls_r - 4'd1;
          end
        end
      end
      if ((mode_r == QM_SPREAD) && !pfound) begin
        // count enabled notes upward until the target one
        k_r <= k_r + 4'd1;
        if (mask_x[k_r]) begin
          if (cnt_r == tgt_r) begin
            sel_r  <= k_r;
            pfound <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
      end
    end

    if (cmd.pick) begin
      note_r <= note_c;
      keep_r <= (mode_r == QM_CLAMP) && !mask_x[aps];
    end

    if (cmd.mul) begin
      u_r    <= u9[7:0];
      prod_r <= {8'd0, u9[7:0]} * 16'd171;
    end

    if (cmd.volt) begin
      v_r <= v_lim[15:0];
    end

    if (cmd.commit) begin
      out_channel <= ch_r;
      held_value  <= v_r;
      changed     <= (v_r != prev_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid               <= 1'b1;
        held[IDX_W'(ch_r)]      <= v_r;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sample_hold_scale_quantizer.sv */
// An accepted request passes through prep, the search step, pick, multiply, volt scaling and
// commit. The search step ends at once in clamp mode or unquantized, else it is a walk of up
// to 11 semitones at one a cycle. The block takes no new request before the last is committed:
// the input stalls from acceptance until the result is in the output register, which can
// still be waiting while the next request enters.
// Reset (rst, synchronous, active high): all held values zero, mode proportional,
// full scale mask, quantizing off on every channel, output empty.
`timescale 1ns / 1ps
`default_nettype none

module sample_hold_scale_quantizer import shsq_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,

  // hold trigger requests
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         channel,
  input  wire logic signed [15:0] sample,

  // held value updates
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_channel,
  output logic signed [15:0]      held_value,
  output logic                    changed,

  // configuration writes
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_data
);

  // Configuration registers. The user must write them only while no request is in flight (the
  // block does not enforce this); the datapath samples them freely during its prep step.
  logic [1:0]  quant_mode;
  logic [11:0] scale_mask;
  logic [2:0]  quant_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_mode   <= MODE_RESET;
      scale_mask   <= MASK_RESET;
      quant_enable <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   quant_mode   <= cfg_data[1:0];
        REG_MASK:   scale_mask   <= cfg_data;
        REG_ENABLE: quant_enable <= cfg_data[2:0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  shsq_cmd_t  cmd;
  shsq_stat_t stat;

  // Controller: sequences capture, prep, the semitone walk, note pick,
  // reciprocal multiply, volt scaling and the commit into the output register.
  shsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: held value store, quantizer arithmetic and the output register.
  shsq_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .channel      (channel),
    .sample       (sample),
    .quant_mode   (quant_mode),
    .scale_mask   (scale_mask),
    .quant_enable (quant_enable),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_channel  (out_channel),
    .held_value   (held_value),
    .changed      (changed)
  );

  // Every result stays inside the five volt window.
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((held_value >= -VMAX) && (held_value <= VMAX)))
    else $error("held value outside five volt range");

  // Results only ever name a channel that exists.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({30'd0, out_channel} < CHANNELS))
    else $error("result for a nonexistent channel");

  // A new result only appears after a request was being worked on.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in flight");

endmodule

`default_nettype wire

/* test/sample_hold_scale_quantizer_test.sv */
`timescale 1ns / 1ps

module sample_hold_scale_quantizer_test;
  import shsq_pkg::*;

  // Pitch arithmetic: 4096 units per semitone after the x12, 49152 per octave.
  localparam int SEMI = 4096;
  localparam int OCT = 49152;
  // Mode code three has no package name; it decodes as proportional.
  localparam logic [1:0] MODE_ALIAS_PROP = 2'd3;
  localparam int NUM_CHANNELS = 3;
  // Drain window after settling; longer than the slowest request takes.
  localparam int DRAIN = 24;
  localparam int LIMIT = 500000;
  localparam int PHASES = 14;
  localparam int PHASE_TRIGGERS = 120;

  typedef struct packed {
    logic [1:0]         ch;
    logic signed [15:0] smp;
  } trigger_t;

  typedef struct packed {
    logic [1:0]         ch;
    logic signed [15:0] value;
    logic               changed;
  } held_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         channel = '0;
  logic signed [15:0] sample = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_channel;
  logic signed [15:0] held_value;
  logic               changed;

  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;

  // Pending hold triggers and the held-value updates they must produce.
  trigger_t     trigger_q[$];
  held_update_t held_update_q[$];

  // Shadow of the block: settings as written, one held value per channel.
  logic [1:0]  mdl_mode = MODE_RESET;
  logic [11:0] mdl_mask = MASK_RESET;
  logic [2:0]  mdl_enable = ENABLE_RESET;
  int          mdl_held [NUM_CHANNELS] = '{0, 0, 0};

  int accepted_triggers = 0;
  int seen_updates = 0;
  int bad_fields = 0;
  int cycles = 0;

  // Receiver hold-off state.
  int hold_left = 0;
  bit hold_done = 1'b0;

  sample_hold_scale_quantizer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .channel     (channel),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .held_value  (held_value),
    .changed     (changed),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int floor_div(int a, int d);
    return (a >= 0) ? a / d : -((-a + d - 1) / d);
  endfunction

  // Semitone note to held volts: round(n * 1024 / 3), which never ties.
  function automatic int note_to_held(int n);
    return floor_div(2048 * n + 3, 6);
  endfunction

  // Test a semitone against the mask with a true modulo for negative notes.
  function automatic bit note_lit(logic [11:0] mask, int k);
    int m;
    m = k % 12;
    if (m < 0) m += 12;
    return mask[m];
  endfunction

  // Snap one trigger to the scale, clamp, update the shadow hold and queue
  // the update it must produce. Drop triggers for channels that do not exist.
  function automatic void snap_and_hold(trigger_t trig);
    logic [11:0]  mask;
    int           s, prev, v, t, off, f, k, a, r, l, dr, dl, m, n;
    int           lit [12];
    held_update_t upd;
    if (trig.ch >= NUM_CHANNELS) return;
    // An empty scale acts as C alone.
    mask = (mdl_mask == '0) ? 12'h001 : mdl_mask;
    s = $signed(trig.smp);
    prev = mdl_held[trig.ch];
    v = s;
    if (mdl_enable[trig.ch]) begin
      t = s * 12;
      off = floor_div(t, OCT);
      f = t - off * OCT;
      case (mdl_mode)
        QM_CLAMP: begin
          // Round halves away from zero; keep the old value on a dark note.
          k = (t >= 0) ? (t + 2048) / SEMI : -((-t + 2048) / SEMI);
          v = note_lit(mask, k) ? note_to_held(k) : prev;
        end
        QM_NEAREST: begin
          a = (f + 2048) / SEMI;
          r = a;
          l = a;
          for (int z = 0; z < 12 && !note_lit(mask, r); z++) r++;
          for (int z = 0; z < 12 && !note_lit(mask, l); z++) l--;
          dr = f - r * SEMI;
          if (dr < 0) dr = -dr;
          dl = f - l * SEMI;
          if (dl < 0) dl = -dl;
          // A tie goes to the upper note.
          v = note_to_held(((dr <= dl) ? r : l) + off * 12);
        end
        default: begin
          // Proportional, also for the alias code: spread the octave evenly.
          m = 0;
          for (int j = 0; j < 12; j++) begin
            if (mask[j]) begin
              lit[m] = j;
              m++;
            end
          end
          n = (2 * m * f + OCT) / (2 * OCT);
          if (n >= m) begin
            n = 0;
            off++;
          end
          v = note_to_held(lit[n] + off * 12);
        end
      endcase
    end
    if (v < -VMAX) v = -VMAX;
    if (v > VMAX) v = VMAX;
    mdl_held[trig.ch] = v;
    upd.ch = trig.ch;
    upd.value = v[15:0];
    upd.changed = (v != prev);
    held_update_q.push_back(upd);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    bad_fields++;
    $display("MISMATCH %s: got %0d, want %0d (update %0d)", what, got, want, seen_updates);
  endtask

  task automatic offer(logic [1:0] ch, int smp);
    trigger_t trig;
    trig.ch = ch;
    trig.smp = smp[15:0];
    trigger_q.push_back(trig);
  endtask

  // Wait until every request is in and every update is out, then let the
  // block finish any request that yields no update.
  task automatic settle();
    do @(negedge clk);
    while (trigger_q.size() != 0 || in_valid || held_update_q.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Write all three registers on consecutive edges while the block is idle.
  task automatic load_settings(logic [1:0] mode, logic [11:0] mask, logic [2:0] en);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data <= {10'd0, mode};
    @(posedge clk);
    cfg_index <= REG_MASK;
    cfg_data <= mask;
    @(posedge clk);
    cfg_index <= REG_ENABLE;
    cfg_data <= {9'd0, en};
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_mode = mode;
    mdl_mask = mask;
    mdl_enable = en;
  endtask

  // Request driver: predict on acceptance, then present the next trigger or
  // idle. Hold the payload while stalled. No idling in the steady stretch.
  always @(posedge clk) begin : drive
    trigger_t nxt;
    bit       go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.ch = channel;
        nxt.smp = sample;
        snap_and_hold(nxt);
        accepted_triggers++;
      end
      if (!in_valid || !in_stall) begin
        go = trigger_q.size() != 0 &&
             ((accepted_triggers >= 800 && accepted_triggers < 1100) ||
              $urandom_range(99) >= 25);
        if (go) begin
          nxt = trigger_q.pop_front();
          channel <= nxt.ch;
          sample <= nxt.smp;
        end
        in_valid <= go;
      end
    end
  end

  // Update monitor: check each accepted update against the oldest one
  // expected, then pick the stall for the next cycle.
  always @(posedge clk) begin : watch
    held_update_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (held_update_q.size() == 0) begin
          flag_mismatch("update with none expected, channel", out_channel, -1);
        end else begin
          want = held_update_q.pop_front();
          if (out_channel !== want.ch)
            flag_mismatch("out_channel", out_channel, want.ch);
          if (held_value !== want.value)
            flag_mismatch("held_value", $signed(held_value), $signed(want.value));
          if (changed !== want.changed)
            flag_mismatch("changed", changed, want.changed);
        end
        seen_updates++;
      end
      // Hold off once for a long stretch mid-run so the block backs up and
      // stalls its requests while the driver keeps offering.
      if (!hold_done && accepted_triggers >= 350) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(seen_updates >= 800 && seen_updates < 1100) &&
                     $urandom_range(99) < 25;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0]  mode;
    logic [11:0] mask;
    logic [2:0]  en;
    logic [1:0]  ch;
    int          smp;
    int          counted;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Quantizing off after reset: rails, pass-through, a return to zero and
    // a trigger for the missing channel, which must vanish.
    offer(2'd0, 32767);
    offer(2'd1, -32768);
    offer(2'd2, 20480);
    offer(2'd0, -20481);
    offer(2'd3, 777);
    offer(2'd1, 20481);
    offer(2'd2, 0);

    // Clamp with every note lit: half-semitone ties round away from zero.
    load_settings(QM_CLAMP, 12'hFFF, 3'b111);
    offer(2'd0, 512);
    offer(2'd1, -512);
    offer(2'd2, -32768);

    // Clamp on a major scale: dark notes keep the old value, including a
    // negative note; channel one is not quantized.
    load_settings(QM_CLAMP, 12'hAB5, 3'b101);
    offer(2'd0, 341);
    offer(2'd1, 341);
    offer(2'd2, -683);

    // Nearest with an empty mask acts as C only.
    load_settings(QM_NEAREST, 12'h000, 3'b111);
    offer(2'd0, 2047);
    offer(2'd1, -1);

    // Nearest with C and F#: exact tie midway goes up; half rounding of a.
    load_settings(QM_NEAREST, 12'h041, 3'b111);
    offer(2'd0, 1024);
    offer(2'd1, -1024);
    offer(2'd2, 512);

    // Alias mode code: proportional, with the wrap into the next octave.
    load_settings(MODE_ALIAS_PROP, 12'h041, 3'b111);
    offer(2'd0, 4095);
    offer(2'd1, -32768);
    offer(2'd2, 32767);

    // Random phases, each under its own settings; extremes come first.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: mode = QM_CLAMP;
        1: mode = QM_NEAREST;
        2: mode = QM_SPREAD;
        default: mode = MODE_ALIAS_PROP;
      endcase
      case (p)
        0: mask = 12'h000;
        1: mask = 12'hFFF;
        2: mask = 12'h001;
        3: mask = 12'h800;
        4: mask = 12'hAB5;
        default: mask = 12'($urandom_range(4095));
      endcase
      en = (p < 9) ? 3'b111 : 3'($urandom_range(7));
      load_settings(mode, mask, en);
      counted = 0;
      while (counted < PHASE_TRIGGERS) begin
        ch = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(9))
          0, 1, 2, 3, 4: smp = int'($urandom);
          5, 6, 7: smp = int'($urandom_range(40960)) - 20480;
          8: begin
            case ($urandom_range(5))
              0: smp = 32767;
              1: smp = -32768;
              2: smp = 20481;
              3: smp = -20481;
              4: smp = 0;
              default: smp = -1;
            endcase
          end
          default: smp = (int'($urandom_range(64)) - 32) * 1024 +
                         int'($urandom_range(2)) - 1;
        endcase
        offer(ch, smp);
        counted++;
      end
    end

    settle();
    if (held_update_q.size() != 0)
      flag_mismatch("updates never seen", 0, held_update_q.size());
    if (bad_fields == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
